// ===== src/pbs_pkg.sv =====
// ----------------------------------------------------------------------------
// pbs_pkg
// Shared types and constants of the palette blink scheduler: table size,
// operation and mode codes, the stored light record and the mode write bundle.
// ----------------------------------------------------------------------------
package pbs_pkg;

	localparam int MAX_LIGHTS = 16;
	localparam int IDX_W      = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
	localparam int MAX_RESULTS = 16;
	localparam int RES_W      = $clog2(MAX_RESULTS + 1);

	localparam int SLOT_W  = 4;
	localparam int PIDX_W  = 8;
	localparam int COLOR_W = 24;
	localparam int TICK_W  = 16;

	typedef enum logic [1:0] {
		KIND_ADD    = 2'd0,
		KIND_DELETE = 2'd1,
		KIND_UPDATE = 2'd2,
		KIND_TICK   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		MODE_FREE = 2'd0,
		MODE_OFF  = 2'd1,
		MODE_ON   = 2'd2,
		MODE_RSVD = 2'd3
	} mode_t;

	typedef logic [IDX_W-1:0] idx_t;

	// One light as kept in the record memory. The mode lives in flops.
	typedef struct packed {
		logic [TICK_W-1:0]  count;
		logic [TICK_W-1:0]  on_dur;
		logic [TICK_W-1:0]  off_dur;
		logic [PIDX_W-1:0]  target;
		logic [COLOR_W-1:0] lit;
		logic [COLOR_W-1:0] dark;
	} light_rec_t;

	typedef struct packed {
		logic  en;
		idx_t  idx;
		mode_t mode;
	} mode_wr_t;

endpackage

// ===== src/palette_blink_scheduler.sv =====
// ----------------------------------------------------------------------------
// palette_blink_scheduler
// Table of blinking lights that drive palette entries. Add, delete and update
// act on one slot; tick walks the record memory one slot per cycle and
// reports each light that switches as a palette write.
//
//   channel   handshake                  payload
//   command   start / busy               kind, slot, target_index, on_color,
//                                        off_color, on_ticks, off_ticks
//   result    result_strobe (one cycle)  failed, result_slot, write_valid,
//                                        palette_index, palette_color, last
//
// Add, delete and update: busy stays low, the single result appears in the
// cycle after the command, and a new command may follow at once.
// Tick: busy while the record memory is read once per slot, then through the
// tail state (the last slot's write-back) and the flush state; its results
// trail the scan by one entry so the final one can carry last.
// Reset clears all slots to free; the record memory needs no clearing.
// The receiver takes every result in its strobe cycle and cannot stall.
// ----------------------------------------------------------------------------
module palette_blink_scheduler
	import pbs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         kind,
	input  logic [SLOT_W-1:0]  slot,
	input  logic [PIDX_W-1:0]  target_index,
	input  logic [COLOR_W-1:0] on_color,
	input  logic [COLOR_W-1:0] off_color,
	input  logic [TICK_W-1:0]  on_ticks,
	input  logic [TICK_W-1:0]  off_ticks,
	output logic               result_strobe,
	output logic               failed,
	output logic [SLOT_W-1:0]  result_slot,
	output logic               write_valid,
	output logic [PIDX_W-1:0]  palette_index,
	output logic [COLOR_W-1:0] palette_color,
	output logic               last
);

	typedef struct packed {
		logic               failed;
		logic [SLOT_W-1:0]  slot;
		logic               wv;
		logic [PIDX_W-1:0]  index;
		logic [COLOR_W-1:0] color;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_ISSUE = 4'b0010,
		ST_TAIL  = 4'b0100,
		ST_FLUSH = 4'b1000
	} state_t;

	state_t     state_q;
	idx_t       rd_idx_q;
	logic       valid_s1;
	idx_t       idx_s1;
	logic       pend_valid_q;
	result_t    pend_q;
	logic [RES_W-1:0] res_cnt_q;
	result_t    out_q;
	logic       strobe_q;
	logic       last_q;

	logic       accept;
	logic       cmd_tick;
	idx_t       cmd_idx;
	logic       slot_in_range;
	mode_t      cmd_mode;
	mode_t      scan_mode;
	logic       free_found;
	idx_t       free_idx;
	light_rec_t new_rec;

	result_t    cmd_res;
	logic       cmd_we;
	idx_t       cmd_addr;
	mode_wr_t   cmd_mode_wr;

	light_rec_t rec_s1;
	logic       used_s1;
	logic [TICK_W:0] count_inc_s1;
	logic [TICK_W-1:0] dur_s1;
	logic       switch_s1;
	light_rec_t wb_rec_s1;
	mode_t      next_mode_s1;
	result_t    tick_res_s1;
	logic       capture_s1;

	logic       ram_we;
	idx_t       ram_wr_addr;
	light_rec_t ram_wr_data;
	mode_wr_t   mode_wr;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign cmd_tick = (kind_t'(kind) == KIND_TICK);
	assign cmd_idx  = IDX_W'(slot);
	assign slot_in_range = (32'(slot) < 32'(MAX_LIGHTS));

	pbs_mode_table u_mode_table (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (mode_wr),
		.cmd_idx    (cmd_idx),
		.scan_idx   (idx_s1),
		.cmd_mode   (cmd_mode),
		.scan_mode  (scan_mode),
		.free_found (free_found),
		.free_idx   (free_idx)
	);

	pbs_light_ram u_light_ram (
		.clk     (clk),
		.we      (ram_we),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.re      (state_q == ST_ISSUE),
		.rd_addr (rd_idx_q),
		.rd_data (rec_s1)
	);

	// Single-slot commands.
	always_comb begin
		new_rec.count   = '0;
		new_rec.on_dur  = on_ticks;
		new_rec.off_dur = off_ticks;
		new_rec.target  = target_index;
		new_rec.lit     = on_color;
		new_rec.dark    = off_color;

		cmd_res         = '0;
		cmd_res.failed  = 1'b1;
		cmd_we          = 1'b0;
		cmd_addr        = cmd_idx;
		cmd_mode_wr     = '0;
		cmd_mode_wr.idx = cmd_idx;
		cmd_mode_wr.mode = MODE_FREE;

		case (kind_t'(kind))
			KIND_ADD: begin
				if (free_found) begin
					cmd_res.failed   = 1'b0;
					cmd_res.slot     = SLOT_W'(free_idx);
					cmd_res.wv       = 1'b1;
					cmd_res.index    = target_index;
					cmd_res.color    = off_color;
					cmd_we           = accept;
					cmd_addr         = free_idx;
					cmd_mode_wr.en   = accept;
					cmd_mode_wr.idx  = free_idx;
					cmd_mode_wr.mode = MODE_OFF;
				end
			end
			KIND_DELETE: begin
				if (slot_in_range && cmd_mode != MODE_FREE) begin
					cmd_res.failed   = 1'b0;
					cmd_res.slot     = slot;
					cmd_mode_wr.en   = accept;
					cmd_mode_wr.mode = MODE_FREE;
				end
			end
			KIND_UPDATE: begin
				if (slot_in_range && cmd_mode != MODE_FREE) begin
					cmd_res.failed = 1'b0;
					cmd_res.slot   = slot;
					cmd_res.wv     = 1'b1;
					cmd_res.index  = target_index;
					cmd_res.color  = (cmd_mode == MODE_ON) ? on_color : off_color;
					cmd_we         = accept;
				end
			end
			default: begin
				cmd_res = '0;
			end
		endcase
	end

	// Tick scan, second stage: the record of idx_s1 has just been read.
	always_comb begin
		used_s1      = valid_s1 && (scan_mode == MODE_OFF || scan_mode == MODE_ON);
		count_inc_s1 = {1'b0, rec_s1.count} + (TICK_W + 1)'(1);
		dur_s1       = (scan_mode == MODE_OFF) ? rec_s1.off_dur : rec_s1.on_dur;
		switch_s1    = used_s1 && (count_inc_s1 >= {1'b0, dur_s1});

		wb_rec_s1       = rec_s1;
		wb_rec_s1.count = switch_s1 ? '0 : count_inc_s1[TICK_W-1:0];
		next_mode_s1    = (scan_mode == MODE_OFF) ? MODE_ON : MODE_OFF;

		tick_res_s1.failed = 1'b0;
		tick_res_s1.slot   = SLOT_W'(idx_s1);
		tick_res_s1.wv     = 1'b1;
		tick_res_s1.index  = rec_s1.target;
		tick_res_s1.color  = (scan_mode == MODE_OFF) ? rec_s1.lit : rec_s1.dark;

		capture_s1 = switch_s1 && (32'(res_cnt_q) < 32'(MAX_RESULTS));
	end

	// Commands and the scan never overlap, so one write port serves both.
	always_comb begin
		if (valid_s1) begin
			ram_we       = used_s1;
			ram_wr_addr  = idx_s1;
			ram_wr_data  = wb_rec_s1;
			mode_wr.en   = switch_s1;
			mode_wr.idx  = idx_s1;
			mode_wr.mode = next_mode_s1;
		end else begin
			ram_we      = cmd_we;
			ram_wr_addr = cmd_addr;
			ram_wr_data = new_rec;
			mode_wr     = cmd_mode_wr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rd_idx_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= (state_q == ST_ISSUE);
			case (state_q)
				ST_IDLE: begin
					rd_idx_q <= '0;
					if (accept && cmd_tick) begin
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					rd_idx_q <= rd_idx_q + IDX_W'(1);
					if (rd_idx_q == IDX_W'(MAX_LIGHTS - 1)) begin
						state_q <= ST_TAIL;
					end
				end
				ST_TAIL: begin
					state_q <= ST_FLUSH;
				end
				ST_FLUSH: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q;
	end

	// A switching light's write is held back one entry so that the final
	// transaction of a tick is known when it leaves and can carry last.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q     <= 1'b0;
			pend_valid_q <= 1'b0;
			res_cnt_q    <= '0;
		end else begin
			strobe_q <= 1'b0;
			if (accept) begin
				res_cnt_q    <= '0;
				pend_valid_q <= 1'b0;
				strobe_q     <= !cmd_tick;
			end else if (capture_s1) begin
				strobe_q     <= pend_valid_q;
				pend_valid_q <= 1'b1;
				res_cnt_q    <= res_cnt_q + RES_W'(1);
			end else if (state_q == ST_FLUSH) begin
				strobe_q     <= 1'b1;
				pend_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q  <= cmd_res;
			last_q <= 1'b1;
		end else if (capture_s1) begin
			out_q  <= pend_q;
			last_q <= 1'b0;
			pend_q <= tick_res_s1;
		end else if (state_q == ST_FLUSH) begin
			out_q  <= pend_valid_q ? pend_q : '0;
			last_q <= 1'b1;
		end
	end

	assign result_strobe = strobe_q;
	assign failed        = out_q.failed;
	assign result_slot   = out_q.slot;
	assign write_valid   = out_q.wv;
	assign palette_index = out_q.index;
	assign palette_color = out_q.color;
	assign last          = last_q;

endmodule

// ===== src/pbs_light_ram.sv =====
// ----------------------------------------------------------------------------
// pbs_light_ram
// Record memory of the light table: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module pbs_light_ram
	import pbs_pkg::*;
(
	input  logic       clk,
	input  logic       we,
	input  idx_t       wr_addr,
	input  light_rec_t wr_data,
	input  logic       re,
	input  idx_t       rd_addr,
	output light_rec_t rd_data
);

	light_rec_t mem [MAX_LIGHTS];
	light_rec_t rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== src/pbs_mode_table.sv =====
// ----------------------------------------------------------------------------
// pbs_mode_table
// Per-slot mode flags, cleared to free at reset. Gives the mode of the
// command slot, the mode of the slot under scan, and the lowest free slot.
// ----------------------------------------------------------------------------
module pbs_mode_table
	import pbs_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  mode_wr_t wr,
	input  idx_t     cmd_idx,
	input  idx_t     scan_idx,
	output mode_t    cmd_mode,
	output mode_t    scan_mode,
	output logic     free_found,
	output idx_t     free_idx
);

	mode_t mode_q [MAX_LIGHTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_LIGHTS; i++) begin
				mode_q[i] <= MODE_FREE;
			end
		end else if (wr.en) begin
			mode_q[wr.idx] <= wr.mode;
		end
	end

	// Index codes past the table end read as free when the size is not a
	// power of two.
	always_comb begin
		cmd_mode  = MODE_FREE;
		scan_mode = MODE_FREE;
		if (32'(cmd_idx) < 32'(MAX_LIGHTS)) begin
			cmd_mode = mode_q[cmd_idx];
		end
		if (32'(scan_idx) < 32'(MAX_LIGHTS)) begin
			scan_mode = mode_q[scan_idx];
		end
	end

	// Walking down from the top leaves the lowest free slot selected.
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = MAX_LIGHTS - 1; i >= 0; i--) begin
			if (mode_q[i] == MODE_FREE) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(i);
			end
		end
	end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Palette blink scheduler testbench
// Random and directed light-table commands go through the start/busy port.
// A behavioral copy of the light table predicts each palette write. Each
// strobed result is checked against the oldest predicted write.
// ----------------------------------------------------------------------------
module testbench;
	import pbs_pkg::*;

	localparam int WATCHDOG_LIMIT = 400;
	localparam int SETTLE_CYCLES  = 2 * (MAX_LIGHTS + 2);

	typedef struct {
		kind_t              kind;
		logic [SLOT_W-1:0]  slot;
		logic [PIDX_W-1:0]  target_index;
		logic [COLOR_W-1:0] on_color;
		logic [COLOR_W-1:0] off_color;
		logic [TICK_W-1:0]  on_ticks;
		logic [TICK_W-1:0]  off_ticks;
		int                 gap;
		bit                 drain;
	} light_cmd_t;

	typedef struct packed {
		logic               failed;
		logic [SLOT_W-1:0]  slot;
		logic               write_valid;
		logic [PIDX_W-1:0]  index;
		logic [COLOR_W-1:0] color;
		logic               last;
	} palette_report_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [1:0]         kind = KIND_ADD;
	logic [SLOT_W-1:0]  slot = '0;
	logic [PIDX_W-1:0]  target_index = '0;
	logic [COLOR_W-1:0] on_color = '0;
	logic [COLOR_W-1:0] off_color = '0;
	logic [TICK_W-1:0]  on_ticks = '0;
	logic [TICK_W-1:0]  off_ticks = '0;
	logic               result_strobe;
	logic               failed;
	logic [SLOT_W-1:0]  result_slot;
	logic               write_valid;
	logic [PIDX_W-1:0]  palette_index;
	logic [COLOR_W-1:0] palette_color;
	logic               last;

	palette_blink_scheduler dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.kind          (kind),
		.slot          (slot),
		.target_index  (target_index),
		.on_color      (on_color),
		.off_color     (off_color),
		.on_ticks      (on_ticks),
		.off_ticks     (off_ticks),
		.result_strobe (result_strobe),
		.failed        (failed),
		.result_slot   (result_slot),
		.write_valid   (write_valid),
		.palette_index (palette_index),
		.palette_color (palette_color),
		.last          (last)
	);

	light_cmd_t      command_queue[$];
	palette_report_t pending_reports[$];
	logic            reports_drained = 1'b1;
	int              error_count = 0;
	int              wait_cnt = 0;
	int              idle_cycles = 0;
	int              planned_count = 0;
	logic [MAX_LIGHTS-1:0] planned_used = '0;

	// Predicted light table.
	mode_t              lamp_mode    [MAX_LIGHTS];
	logic [TICK_W-1:0]  lamp_count   [MAX_LIGHTS];
	logic [TICK_W-1:0]  lamp_on_len  [MAX_LIGHTS];
	logic [TICK_W-1:0]  lamp_off_len [MAX_LIGHTS];
	logic [PIDX_W-1:0]  lamp_target  [MAX_LIGHTS];
	logic [COLOR_W-1:0] lamp_lit     [MAX_LIGHTS];
	logic [COLOR_W-1:0] lamp_dark    [MAX_LIGHTS];

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic string report_text(input palette_report_t r);
		return $sformatf("failed=%0d slot=%0d write_valid=%0d index=%0d color=%06h last=%0d",
			r.failed, r.slot, r.write_valid, r.index, r.color, r.last);
	endfunction

	task automatic load_lamp(input int i, input logic [PIDX_W-1:0] idx,
			input logic [COLOR_W-1:0] on_c, input logic [COLOR_W-1:0] off_c,
			input logic [TICK_W-1:0] on_t, input logic [TICK_W-1:0] off_t);
		lamp_target[i]  = idx;
		lamp_lit[i]     = on_c;
		lamp_dark[i]    = off_c;
		lamp_on_len[i]  = on_t;
		lamp_off_len[i] = off_t;
		lamp_count[i]   = '0;
	endtask

	// Applies one accepted command to the predicted table and queues the
	// palette writes it is expected to produce.
	task automatic apply_light_command(input kind_t op, input logic [SLOT_W-1:0] s,
			input logic [PIDX_W-1:0] idx, input logic [COLOR_W-1:0] on_c,
			input logic [COLOR_W-1:0] off_c, input logic [TICK_W-1:0] on_t,
			input logic [TICK_W-1:0] off_t);
		palette_report_t  batch [MAX_RESULTS];
		palette_report_t  r;
		int               n;
		int               free_slot;
		bit               slot_used;
		logic [TICK_W:0]  next_count;
		logic [TICK_W-1:0] span;
		n = 0;
		for (int k = 0; k < MAX_RESULTS; k++)
			batch[k] = '0;
		slot_used = (int'(s) < MAX_LIGHTS) && (lamp_mode[s] != MODE_FREE);
		case (op)
			KIND_ADD: begin
				free_slot = -1;
				for (int i = MAX_LIGHTS - 1; i >= 0; i--)
					if (lamp_mode[i] == MODE_FREE)
						free_slot = i;
				if (free_slot >= 0) begin
					load_lamp(free_slot, idx, on_c, off_c, on_t, off_t);
					lamp_mode[free_slot] = MODE_OFF;
					batch[0] = '{1'b0, SLOT_W'(free_slot), 1'b1, idx, off_c, 1'b0};
				end else begin
					batch[0].failed = 1'b1;
				end
				n = 1;
			end
			KIND_DELETE: begin
				if (slot_used) begin
					lamp_mode[s] = MODE_FREE;
					batch[0].slot = s;
				end else begin
					batch[0].failed = 1'b1;
				end
				n = 1;
			end
			KIND_UPDATE: begin
				if (slot_used) begin
					load_lamp(s, idx, on_c, off_c, on_t, off_t);
					batch[0] = '{1'b0, s, 1'b1, idx,
						(lamp_mode[s] == MODE_ON) ? on_c : off_c, 1'b0};
				end else begin
					batch[0].failed = 1'b1;
				end
				n = 1;
			end
			default: begin
				for (int i = 0; i < MAX_LIGHTS; i++) begin
					if (lamp_mode[i] == MODE_OFF || lamp_mode[i] == MODE_ON) begin
						next_count = {1'b0, lamp_count[i]} + 1'b1;
						span = (lamp_mode[i] == MODE_OFF) ? lamp_off_len[i] : lamp_on_len[i];
						if (next_count >= {1'b0, span}) begin
							lamp_count[i] = '0;
							// Writes beyond the result limit are dropped, but the
							// light still switches.
							if (n < MAX_RESULTS) begin
								batch[n] = '{1'b0, SLOT_W'(i), 1'b1, lamp_target[i],
									(lamp_mode[i] == MODE_OFF) ? lamp_lit[i] : lamp_dark[i],
									1'b0};
								n++;
							end
							lamp_mode[i] = (lamp_mode[i] == MODE_OFF) ? MODE_ON : MODE_OFF;
						end else begin
							lamp_count[i] = next_count[TICK_W-1:0];
						end
					end
				end
				if (n == 0)
					n = 1;
			end
		endcase
		for (int k = 0; k < n; k++) begin
			r = batch[k];
			r.last = (k == n - 1);
			pending_reports.push_back(r);
		end
	endtask

	task automatic queue_command(input kind_t op, input logic [SLOT_W-1:0] s,
			input logic [PIDX_W-1:0] idx, input logic [COLOR_W-1:0] on_c,
			input logic [COLOR_W-1:0] off_c, input logic [TICK_W-1:0] on_t,
			input logic [TICK_W-1:0] off_t, input bit drain);
		light_cmd_t c;
		c = '{op, s, idx, on_c, off_c, on_t, off_t, 0, drain};
		// Every fourth block of twenty commands is sent back to back.
		c.gap = ((planned_count / 20) % 4 == 3) ? 0 : $urandom_range(0, 4);
		planned_count++;
		if (op == KIND_ADD) begin
			for (int i = 0; i < MAX_LIGHTS; i++)
				if (!planned_used[i]) begin
					planned_used[i] = 1'b1;
					break;
				end
		end else if (op == KIND_DELETE) begin
			planned_used[s] = 1'b0;
		end
		command_queue.push_back(c);
	endtask

	function automatic logic [TICK_W-1:0] pick_duration();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return TICK_W'($urandom_range(0, 4));
		else if (r < 85)
			return TICK_W'($urandom);
		case ($urandom_range(0, 3))
			0: return '0;
			1: return TICK_W'(1);
			2: return '1;
			default: return '1 - 1'b1;
		endcase
	endfunction

	function automatic logic [SLOT_W-1:0] pick_slot();
		int used_list[$];
		for (int i = 0; i < MAX_LIGHTS; i++)
			if (planned_used[i])
				used_list.push_back(i);
		if (used_list.size() > 0 && $urandom_range(0, 99) < 85)
			return SLOT_W'(used_list[$urandom_range(0, used_list.size() - 1)]);
		return SLOT_W'($urandom_range(0, MAX_LIGHTS - 1));
	endfunction

	// Driver: holds the front command on the port until it is accepted.
	always @(posedge clk) begin : drive
		logic go;
		go = start;
		if (start && !busy) begin
			go = 1'b0;
			void'(command_queue.pop_front());
			wait_cnt = 0;
		end
		if (arst_n && !go && command_queue.size() > 0) begin
			if (wait_cnt < command_queue[0].gap) begin
				wait_cnt++;
			end else if (!command_queue[0].drain || (!start && reports_drained)) begin
				kind         <= command_queue[0].kind;
				slot         <= command_queue[0].slot;
				target_index <= command_queue[0].target_index;
				on_color     <= command_queue[0].on_color;
				off_color    <= command_queue[0].off_color;
				on_ticks     <= command_queue[0].on_ticks;
				off_ticks    <= command_queue[0].off_ticks;
				go = 1'b1;
			end
		end
		start <= go;
	end

	// Monitor: checks the strobed result first, then predicts the results of
	// a transaction accepted at this edge.
	always @(posedge clk) begin : observe
		palette_report_t seen;
		palette_report_t want;
		if (arst_n) begin
			if (result_strobe) begin
				seen = '{failed, result_slot, write_valid, palette_index, palette_color, last};
				if (pending_reports.size() == 0) begin
					$display("%0t: result with none expected: actual %s", $time, report_text(seen));
					error_count++;
				end else begin
					want = pending_reports.pop_front();
					if (seen !== want) begin
						$display("%0t: result mismatch: expected %s", $time, report_text(want));
						$display("%0t:                   actual %s", $time, report_text(seen));
						error_count++;
					end
				end
			end
			if (start && !busy)
				apply_light_command(kind_t'(kind), slot, target_index, on_color, off_color,
					on_ticks, off_ticks);
		end
		reports_drained <= (pending_reports.size() == 0);
	end

	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((start && !busy) || result_strobe)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("testbench NOT OK");
				$finish;
			end
		end
	end

	initial begin : stimulus
		kind_t op;
		int    r;
		int    settle;
		for (int i = 0; i < MAX_LIGHTS; i++)
			lamp_mode[i] = MODE_FREE;

		// Directed part: empty table, free slots, field extremes, full table.
		queue_command(KIND_TICK, '0, '0, '0, '0, '0, '0, 1'b0);
		queue_command(KIND_DELETE, '0, '0, '0, '0, '0, '0, 1'b0);
		queue_command(KIND_UPDATE, '1, '1, '1, '1, '1, '1, 1'b0);
		queue_command(KIND_ADD, '0, '1, '1, '0, '0, '0, 1'b0);
		queue_command(KIND_ADD, '0, '0, '0, '1, '1, TICK_W'(1), 1'b0);
		queue_command(KIND_TICK, '1, '1, '1, '1, '1, '1, 1'b0);
		queue_command(KIND_TICK, '0, '0, '0, '0, '0, '0, 1'b0);
		queue_command(KIND_UPDATE, '0, 8'h5A, 24'hA5A5A5, 24'h5A5A5A, TICK_W'(2), TICK_W'(3),
			1'b0);
		queue_command(KIND_UPDATE, SLOT_W'(1), '1, '0, '1, '1, '0, 1'b0);
		queue_command(KIND_DELETE, SLOT_W'(1), '0, '0, '0, '0, '0, 1'b0);
		queue_command(KIND_DELETE, SLOT_W'(1), '0, '0, '0, '0, '0, 1'b0);
		for (int i = 1; i < MAX_LIGHTS; i++)
			queue_command(KIND_ADD, '0, PIDX_W'($urandom), COLOR_W'($urandom),
				COLOR_W'($urandom), '0, '0, 1'b0);
		queue_command(KIND_ADD, '0, '1, '1, '1, '1, '1, 1'b0);
		queue_command(KIND_TICK, '0, '0, '0, '0, '0, '0, 1'b0);
		queue_command(KIND_TICK, '0, '0, '0, '0, '0, '0, 1'b1);

		// Random part: mostly operations on lights in use.
		for (int k = 0; k < 190; k++) begin
			r = $urandom_range(0, 99);
			if (r < 25)
				op = KIND_ADD;
			else if (r < 42)
				op = KIND_DELETE;
			else if (r < 60)
				op = KIND_UPDATE;
			else
				op = KIND_TICK;
			queue_command(op, pick_slot(), PIDX_W'($urandom), COLOR_W'($urandom),
				COLOR_W'($urandom), pick_duration(), pick_duration(),
				$urandom_range(0, 39) == 0);
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (command_queue.size() != 0 || start);
		@(posedge clk);
		settle = 0;
		while (pending_reports.size() != 0 && settle < 20 * WATCHDOG_LIMIT) begin
			@(posedge clk);
			settle++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (pending_reports.size() != 0) begin
			$display("%0t: %0d expected results never arrived, oldest %s", $time,
				pending_reports.size(), report_text(pending_reports[0]));
			error_count++;
		end
		if (error_count == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
